/* design/xtv_pkg.sv */
// Shared types and constants for the XML tag value extractor.
`default_nettype none

package xtv_pkg;

	// Default sizes
	localparam int VALUE_BYTES_DEF = 64;
	localparam int NAME_BYTES_DEF  = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_NAME_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_NAME_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_NAME_LENGTH = 2'd2;

	// Name position counter
	localparam int NAME_POS_W = 5;
	localparam logic [NAME_POS_W-1:0] NAME_POS_MAX = 5'd31;

	// Markup characters
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LT    = 8'h3C;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_GT    = 8'h3E;

	// Controller to datapath commands
	typedef struct packed {
		logic scan_en;    // input transaction this cycle
		logic emit_start; // latch run info, clear read index
		logic rd_issue;   // read value store
		logic step;       // advance read index
	} xtv_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic emit_req;   // current input byte closes a matching element
		logic emit_empty; // that element has no value bytes
		logic run_last;   // byte on output is the last of its run
	} xtv_stat_t;

endpackage

`default_nettype wire

/* design/xtv_ram.sv */
// Generic single write, single read RAM with registered read data.
`default_nettype none

module xtv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/xtv_ctrl.sv */
// Controller: alternates between scanning input and sending a value run.
`default_nettype none

module xtv_ctrl
	import xtv_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire xtv_stat_t stat,
	output xtv_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_SCAN,
		ST_LOAD,
		ST_SEND
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_fire;

	assign in_fire  = in_ready_q & s_tvalid;
	assign out_fire = out_valid_q & m_tready;
	assign s_tready = in_ready_q;
	assign m_tvalid = out_valid_q;

	// Commands to the datapath
	always_comb begin
		cmd.scan_en    = in_fire;
		cmd.emit_start = in_fire & stat.emit_req;
		cmd.step       = out_fire & ~stat.run_last;
		cmd.rd_issue   = (state_q == ST_LOAD) | (out_fire & ~stat.run_last);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SCAN: begin
				if (in_fire && stat.emit_req) begin
					state_d = stat.emit_empty ? ST_SEND : ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_SEND;
			end
			ST_SEND: begin
				if (out_fire && stat.run_last) begin
					state_d = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_SCAN;
			end
		endcase
	end

	// State and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			in_ready_q  <= (state_d == ST_SCAN);
			out_valid_q <= (state_d == ST_SEND);
		end
	end

endmodule

`default_nettype wire

/* design/xtv_datapath.sv */
// Datapath: tag scanner, name compare, value capture store and run readout.
`default_nettype none

module xtv_datapath
	import xtv_pkg::*;
#(
	parameter int VALUE_BYTES = VALUE_BYTES_DEF,
	parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [7:0]            s_tdata,
	output logic      [7:0]            m_tdata,
	output logic                       m_tlast,
	output logic      [1:0]            m_tuser,
	input  wire xtv_cmd_t              cmd,
	output xtv_stat_t                  stat
);

	localparam int AW = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
	localparam int CW = $clog2(VALUE_BYTES + 2);
	localparam logic [CW-1:0] CNT_CAP = CW'(VALUE_BYTES);
	localparam logic [CW-1:0] CNT_SAT = CW'(VALUE_BYTES + 1);
	localparam logic [NAME_POS_W-1:0] NAME_LIMIT = NAME_POS_W'(NAME_BYTES);

	typedef enum logic [1:0] {
		PH_OUTSIDE,
		PH_TAG_START,
		PH_IN_NAME
	} phase_t;

	// Configuration registers
	logic [63:0]           name_low_q;
	logic [63:0]           name_high_q;
	logic [NAME_POS_W-1:0] name_len_q;

	// Scanner state
	phase_t                phase_q,   phase_d;
	logic                  closing_q, closing_d;
	logic [NAME_POS_W-1:0] pos_q,     pos_d;
	logic                  mis_q,     mis_d;
	logic                  open_q,    open_d;
	logic [CW-1:0]         count_q,   count_d;
	logic [CW-1:0]         mark_q,    mark_d;
	logic                  ovf_q,     ovf_d;

	// Run readout registers
	logic [CW-1:0]         run_len_q;
	logic                  run_empty_q;
	logic                  run_trunc_q;
	logic [AW-1:0]         idx_q;

	logic [7:0]            byte_in;
	logic                  is_nul;
	logic                  is_lt;
	logic                  is_gt;
	logic                  is_slash;
	logic                  finish;
	logic                  match;
	logic                  open_match;
	logic                  close_match;
	logic [127:0]          name_all;
	logic [7:0]            wanted;
	logic                  feed_bad;
	logic                  ram_we;
	logic [AW-1:0]         ram_raddr;
	logic [7:0]            ram_rdata;

	assign byte_in  = s_tdata;
	assign is_nul   = (byte_in == CHAR_NUL);
	assign is_lt    = (byte_in == CHAR_LT);
	assign is_gt    = (byte_in == CHAR_GT);
	assign is_slash = (byte_in == CHAR_SLASH);

	// Name byte compare
	assign name_all = {name_high_q, name_low_q};
	assign wanted   = name_all[{pos_q[3:0], 3'b000} +: 8];
	assign feed_bad = (pos_q >= name_len_q) || (pos_q >= NAME_LIMIT) || (wanted != byte_in);

	// Tag end decisions
	assign finish = is_nul ? (phase_q != PH_OUTSIDE)
	                       : ((phase_q != PH_OUTSIDE) && is_gt && !(phase_q == PH_TAG_START && 1'b0));
	assign match       = !mis_q && (pos_q == name_len_q);
	assign open_match  = finish && match && !closing_q;
	assign close_match = finish && match && closing_q && open_q;

	assign stat.emit_req   = close_match;
	assign stat.emit_empty = (mark_q == '0);
	assign stat.run_last   = run_empty_q || ((CW'(idx_q) + CW'(1)) == run_len_q);

	// Scanner next state
	always_comb begin
		phase_d   = phase_q;
		closing_d = closing_q;
		pos_d     = pos_q;
		mis_d     = mis_q;
		open_d    = open_q;
		count_d   = count_q;
		mark_d    = mark_q;
		ovf_d     = ovf_q;
		if (is_nul) begin
			phase_d   = PH_OUTSIDE;
			closing_d = 1'b0;
			pos_d     = '0;
			mis_d     = 1'b0;
			open_d    = 1'b0;
			count_d   = '0;
			mark_d    = '0;
			ovf_d     = 1'b0;
		end else begin
			// snapshot value length at a tag start
			if (phase_q == PH_OUTSIDE && is_lt) begin
				mark_d = (count_q > CNT_CAP) ? CNT_CAP : count_q;
				ovf_d  = (count_q > CNT_CAP);
			end
			// every byte after an opening match counts toward the value
			if (open_q && count_q < CNT_SAT) begin
				count_d = count_q + CW'(1);
			end
			unique case (phase_q)
				PH_OUTSIDE: begin
					if (is_lt) begin
						phase_d   = PH_TAG_START;
						closing_d = 1'b0;
						pos_d     = '0;
						mis_d     = 1'b0;
					end
				end
				PH_TAG_START: begin
					if (is_slash) begin
						closing_d = 1'b1;
						phase_d   = PH_IN_NAME;
					end else if (!is_gt) begin
						mis_d   = mis_q | feed_bad;
						pos_d   = (pos_q < NAME_POS_MAX) ? pos_q + NAME_POS_W'(1) : pos_q;
						phase_d = PH_IN_NAME;
					end
				end
				PH_IN_NAME: begin
					if (!is_gt) begin
						mis_d = mis_q | feed_bad;
						pos_d = (pos_q < NAME_POS_MAX) ? pos_q + NAME_POS_W'(1) : pos_q;
					end
				end
				default: begin
					phase_d = PH_OUTSIDE;
				end
			endcase
			if (finish) begin
				if (open_match || close_match) begin
					open_d  = open_match;
					count_d = '0;
					mark_d  = '0;
					ovf_d   = 1'b0;
				end
				phase_d   = PH_OUTSIDE;
				closing_d = 1'b0;
				pos_d     = '0;
				mis_d     = 1'b0;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_low_q  <= '0;
			name_high_q <= '0;
			name_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TAG_NAME_LOW:    name_low_q  <= cfg_data[63:0];
				CFG_TAG_NAME_HIGH:   name_high_q <= cfg_data[63:0];
				CFG_TAG_NAME_LENGTH: name_len_q  <= cfg_data[NAME_POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Scanner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OUTSIDE;
			closing_q <= 1'b0;
			pos_q     <= '0;
			mis_q     <= 1'b0;
			open_q    <= 1'b0;
			count_q   <= '0;
			mark_q    <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.scan_en) begin
			phase_q   <= phase_d;
			closing_q <= closing_d;
			pos_q     <= pos_d;
			mis_q     <= mis_d;
			open_q    <= open_d;
			count_q   <= count_d;
			mark_q    <= mark_d;
			ovf_q     <= ovf_d;
		end
	end

	// Run readout registers
	always_ff @(posedge clk) begin
		if (cmd.emit_start) begin
			run_len_q   <= mark_q;
			run_empty_q <= (mark_q == '0);
			run_trunc_q <= ovf_q;
			idx_q       <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// Value store
	assign ram_we    = cmd.scan_en && !is_nul && open_q && (count_q < CNT_CAP);
	assign ram_raddr = cmd.step ? idx_q + AW'(1) : idx_q;

	xtv_ram #(
		.WIDTH (8),
		.DEPTH (VALUE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (byte_in),
		.re    (cmd.rd_issue),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output payload
	assign m_tdata = run_empty_q ? 8'h00 : ram_rdata;
	assign m_tlast = stat.run_last;
	assign m_tuser = {run_trunc_q, run_empty_q};

endmodule

`default_nettype wire

/* design/xml_tag_value_extractor.sv */
// Top level of the XML tag value extractor: controller plus datapath.
//
//  channel  direction  handshake                 payload
//  s_*      in         s_tvalid / s_tready       s_tdata = text_byte
//  m_*      out        m_tvalid / m_tready       m_tdata = value_byte, m_tlast = last_of_value,
//                                                m_tuser = {value_truncated, value_empty}
//  cfg_*    in         cfg_we (no wait)          cfg_index, cfg_data
//
// Scanning takes one text byte per cycle while s_tready is high, a single
// tag-state update per byte. A closing match holds off input for the run: a
// load state fetches the first byte from the value store, then the run goes
// out one byte per cycle while m_tready is high; an empty value skips the load
// state and sends a single zero byte. The value store needs no clearing pass
// after reset; a held-off output keeps its byte stable until taken.
`default_nettype none

module xml_tag_value_extractor
	import xtv_pkg::*;
#(
	parameter int VALUE_BYTES = VALUE_BYTES_DEF,
	parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] text_byte
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [7:0]            m_tdata,   // [7:0] value_byte
	output logic                       m_tlast,
	output logic      [1:0]            m_tuser    // [0] value_empty, [1] value_truncated
);

	xtv_cmd_t  cmd;
	xtv_stat_t stat;

	xtv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	xtv_datapath #(
		.VALUE_BYTES (VALUE_BYTES),
		.NAME_BYTES  (NAME_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the XML tag value extractor: directed script, then random documents.
module testbench;
	import xtv_pkg::*;

	localparam int STALL_LIMIT = 3000;  // cycles with no transaction on either side
	localparam int HOLD_CYCLES = 200;   // one long output back-pressure stretch

	// One extracted value byte with its flags
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
		logic       trunc;
	} value_rec_t;

	typedef enum logic [1:0] {SCAN_TEXT, SCAN_TAG_OPEN, SCAN_TAG_NAME} scan_phase_t;
	typedef enum logic [1:0] {TAG_WANTED, TAG_WRONG, TAG_LONG} tag_style_t;
	typedef enum logic {ROW_TEXT, ROW_NAME} row_kind_t;

	// Directed script row: a text byte (optionally with a hand-written result) or a name setting
	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  text;
		logic        marked;
		value_rec_t  want;
		logic [63:0] name_low;
		logic [4:0]  name_len;
	} script_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;   // [7:0] text_byte
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;          // [7:0] value_byte
	logic                  m_tlast;
	logic [1:0]            m_tuser;          // [0] value_empty, [1] value_truncated

	// Hand-written result riding along with the current input transaction
	logic                  s_marked  = 1'b0;
	value_rec_t            s_marked_rec = '0;

	xml_tag_value_extractor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Extractor model: configured name and scan state
	// ---------------------------------------------------------------
	logic [63:0]  want_lo = '0;
	logic [63:0]  want_hi = '0;
	logic [4:0]   want_len = '0;
	scan_phase_t  scan_ph = SCAN_TEXT;
	logic         in_closing = 1'b0;
	logic [4:0]   name_pos = '0;
	logic         name_bad = 1'b0;
	logic         open_pending = 1'b0;
	logic [7:0]   value_mem [VALUE_BYTES_DEF];
	int unsigned  value_len = 0;    // saturates at VALUE_BYTES_DEF + 1
	int unsigned  value_mark = 0;   // value length snapshot at each '<' outside a tag
	logic         value_cut = 1'b0;
	value_rec_t   emitted_now[$];
	value_rec_t   pending_values[$];

	// counters
	int           mismatches = 0;
	int           texts_taken = 0;
	int           results_seen = 0;
	int           names_set = 0;
	int           phase_items = 0;
	int unsigned  dead_cycles = 0;
	bit           steady = 1'b0;     // no random idling on either side while set (the long hold still applies)

	function automatic void clear_scan_state();
		scan_ph      = SCAN_TEXT;
		in_closing   = 1'b0;
		name_pos     = '0;
		name_bad     = 1'b0;
		open_pending = 1'b0;
		value_len    = 0;
		value_mark   = 0;
		value_cut    = 1'b0;
	endfunction

	function automatic void take_name_byte(input logic [7:0] b);
		logic [127:0] full_name;
		full_name = {want_hi, want_lo};
		if (name_pos >= want_len || name_pos >= NAME_BYTES_DEF)
			name_bad = 1'b1;
		else if (full_name[8*name_pos +: 8] != b)
			name_bad = 1'b1;
		if (name_pos != NAME_POS_MAX)
			name_pos++;
	endfunction

	// '>' or end of document: compare the name, open capture or emit the value
	function automatic void end_tag();
		int unsigned i;
		if (!name_bad && name_pos == want_len) begin
			if (!in_closing) begin
				open_pending = 1'b1;
				value_len    = 0;
				value_mark   = 0;
				value_cut    = 1'b0;
			end else if (open_pending) begin
				if (value_mark == 0)
					emitted_now.push_back(value_rec_t'{8'h00, 1'b1, 1'b1, 1'b0});
				else
					for (i = 0; i < value_mark; i++)
						emitted_now.push_back(value_rec_t'{value_mem[i], i + 1 == value_mark,
							1'b0, value_cut});
				open_pending = 1'b0;
				value_len    = 0;
				value_mark   = 0;
				value_cut    = 1'b0;
			end
		end
		scan_ph    = SCAN_TEXT;
		in_closing = 1'b0;
		name_pos   = '0;
		name_bad   = 1'b0;
	endfunction

	function automatic void predict_text(input logic [7:0] b);
		if (b == CHAR_NUL) begin
			if (scan_ph != SCAN_TEXT)
				end_tag();
			clear_scan_state();
		end else begin
			if (scan_ph == SCAN_TEXT && b == CHAR_LT) begin
				value_cut  = value_len > VALUE_BYTES_DEF;
				value_mark = value_cut ? VALUE_BYTES_DEF : value_len;
			end
			// capture runs on every byte once an opening tag matched
			if (open_pending) begin
				if (value_len < VALUE_BYTES_DEF)
					value_mem[value_len] = b;
				if (value_len <= VALUE_BYTES_DEF)
					value_len++;
			end
			case (scan_ph)
				SCAN_TEXT: begin
					if (b == CHAR_LT) begin
						scan_ph    = SCAN_TAG_OPEN;
						in_closing = 1'b0;
						name_pos   = '0;
						name_bad   = 1'b0;
					end
				end
				SCAN_TAG_OPEN: begin
					if (b == CHAR_SLASH) begin
						in_closing = 1'b1;
						scan_ph    = SCAN_TAG_NAME;
					end else if (b == CHAR_GT) begin
						end_tag();
					end else begin
						take_name_byte(b);
						scan_ph = SCAN_TAG_NAME;
					end
				end
				default: begin
					if (b == CHAR_GT)
						end_tag();
					else
						take_name_byte(b);
				end
			endcase
		end
	endfunction

	// ---------------------------------------------------------------
	// Monitor: predict on each input transaction, check each output one
	// ---------------------------------------------------------------
	task automatic report_field(input string field, input logic [7:0] want, input logic [7:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin
		value_rec_t due;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_text(s_tdata);
				if (s_marked) begin
					emitted_now.delete();
					emitted_now.push_back(s_marked_rec);
				end
				while (emitted_now.size() != 0)
					pending_values.push_back(emitted_now.pop_front());
				texts_taken++;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_values.size() == 0) begin
					$display("%0t: unexpected value byte %0h, last %0b, flags %b", $time,
						m_tdata, m_tlast, m_tuser);
					mismatches++;
				end else begin
					due = pending_values.pop_front();
					if (due.data != m_tdata)
						report_field("value_byte", due.data, m_tdata);
					if (due.last != m_tlast)
						report_field("last_of_value", 8'(due.last), 8'(m_tlast));
					if (due.empty != m_tuser[0])
						report_field("value_empty", 8'(due.empty), 8'(m_tuser[0]));
					if (due.trunc != m_tuser[1])
						report_field("value_truncated", 8'(due.trunc), 8'(m_tuser[1]));
				end
			end
			dead_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0 : dead_cycles + 1;
		end
	end

	// Watchdog
	initial begin
		while (dead_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no transaction for %0d cycles, %0d value bytes still due", $time,
			STALL_LIMIT, pending_values.size());
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: random back-pressure plus one long hold while a long run is queued
	initial begin
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && pending_values.size() > 10) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 26);
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	task automatic send_text(input logic [7:0] b, input bit marked = 1'b0,
			input value_rec_t want = '0);
		while (!steady && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid     <= 1'b1;
		s_tdata      <= b;
		s_marked     <= marked;
		s_marked_rec <= want;
		do @(posedge clk); while (!s_tready);
		phase_items++;
	endtask

	// Let every due result drain and the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_values.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_TAG_NAME_LOW:    want_lo  = data;
			CFG_TAG_NAME_HIGH:   want_hi  = data;
			CFG_TAG_NAME_LENGTH: want_len = data[4:0];
			default: ;
		endcase
	endtask

	task automatic set_name(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len);
		write_reg(CFG_TAG_NAME_LOW, lo);
		write_reg(CFG_TAG_NAME_HIGH, hi);
		write_reg(CFG_TAG_NAME_LENGTH, {{(CFG_DATA_W-5){1'b0}}, len});
		cfg_we <= 1'b0;
		names_set++;
	endtask

	// Any byte that keeps a tag name going; a leading '/' would make it a closing tag
	function automatic logic [7:0] legal_name_byte(input bit first);
		logic [7:0] b;
		do b = 8'($urandom_range(255, 1)); while (b == CHAR_GT || (first && b == CHAR_SLASH));
		return b;
	endfunction

	task automatic pick_name(input bit all_ones, input int shortest, input int longest);
		logic [127:0] nm;
		int           len, i;
		len = $urandom_range(longest, shortest);
		if (all_ones) begin
			nm = '1;
		end else begin
			nm = {$urandom, $urandom, $urandom, $urandom};
			for (i = 0; i < len && i < NAME_BYTES_DEF; i++)
				nm[8*i +: 8] = legal_name_byte(i == 0);
		end
		set_name(nm[63:0], nm[127:64], 5'(len));
	endtask

	// Mostly short values, now and then one near or past the store capacity
	function automatic int value_size();
		return ($urandom_range(24) == 0) ? $urandom_range(70, 60) : $urandom_range(8);
	endfunction

	task automatic put_tag(input bit closing, input tag_style_t style, input bit cut = 1'b0);
		logic [127:0] wanted;
		logic [7:0]   label[$];
		logic [7:0]   b;
		int           n, i;
		wanted = {want_hi, want_lo};
		n = want_len;
		if (style == TAG_LONG)
			n = $urandom_range(40, 32);
		else if (style == TAG_WRONG && (n == 0 || $urandom_range(1)))
			n = n + $urandom_range(3, 1);
		for (i = 0; i < n; i++)
			label.push_back((style != TAG_LONG && i < want_len && i < NAME_BYTES_DEF) ?
				wanted[8*i +: 8] : legal_name_byte(i == 0));
		// same length but one byte off
		if (style == TAG_WRONG && n == want_len) begin
			i = $urandom_range(n - 1);
			do b = legal_name_byte(i == 0); while (b == label[i]);
			label[i] = b;
		end
		send_text(CHAR_LT);
		if (closing)
			send_text(CHAR_SLASH);
		foreach (label[k])
			send_text(label[k]);
		send_text(cut ? CHAR_NUL : CHAR_GT);
	endtask

	task automatic put_value(input int n);
		logic [7:0] b;
		int         i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				// nested element inside the value
				send_text(CHAR_LT);
				send_text(legal_name_byte(1'b1));
				send_text(CHAR_GT);
			end else begin
				do b = 8'($urandom_range(255, 1)); while (b == CHAR_LT);
				send_text(b);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Directed script
	// ---------------------------------------------------------------
	script_row_t script[$];

	task automatic add_byte(input logic [7:0] b, input bit marked = 1'b0,
			input value_rec_t want = '0);
		script_row_t row;
		row        = '0;
		row.kind   = ROW_TEXT;
		row.text   = b;
		row.marked = marked;
		row.want   = want;
		script.push_back(row);
	endtask

	// result, if given, belongs to the last character
	task automatic add_text(input string s, input bit marked = 1'b0,
			input value_rec_t want = '0);
		int i;
		for (i = 0; i < s.len(); i++)
			add_byte(s[i], marked && i == s.len() - 1, want);
	endtask

	task automatic add_name(input logic [63:0] lo, input logic [4:0] len);
		script_row_t row;
		row          = '0;
		row.kind     = ROW_NAME;
		row.name_low = lo;
		row.name_len = len;
		script.push_back(row);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int phase_no, pick;
		for (int i = 0; i < VALUE_BYTES_DEF; i++)
			value_mem[i] = '0;
		clear_scan_state();

		// Name length 0 from reset: empty tags match
		add_text("</>");                                                 // close, nothing open
		add_text("<></>", 1'b1, value_rec_t'{8'h00, 1'b1, 1'b1, 1'b0});  // empty value
		add_text("<>");
		add_byte(8'hFF);
		add_text("</");
		add_byte(CHAR_NUL, 1'b1, value_rec_t'{8'hFF, 1'b1, 1'b0, 1'b0}); // cut-off close still matches
		// Name "a<": a '<' inside a tag is just a name byte
		add_name(64'h0000_0000_0000_3C61, 5'd2);
		add_text("<a<>");
		add_text("</a<>", 1'b1, value_rec_t'{8'h00, 1'b1, 1'b1, 1'b0});
		add_text("<a<>k");
		add_byte(CHAR_NUL);                                              // open pending, no output

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			if (script[k].kind == ROW_NAME) begin
				settle();
				set_name(script[k].name_low, '0, script[k].name_len);
			end else begin
				send_text(script[k].text, script[k].marked, script[k].want);
			end
		end

		// Random documents, one tag name setting per phase
		for (phase_no = 0; phase_no < 5; phase_no++) begin
			settle();
			case (phase_no)
				0:       pick_name(1'b1, 16, 16);
				1:       pick_name(1'b0, 1, 8);
				2:       pick_name(1'b0, 17, 31);
				default: pick_name(1'b0, 0, 16);
			endcase
			steady      = (phase_no == 1);
			phase_items = 0;
			if (phase_no == 1) begin
				// value past the store capacity, sent with no idling
				put_tag(1'b0, TAG_WANTED);
				put_value(66);
				put_tag(1'b1, TAG_WANTED);
			end
			while (phase_items < 10) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					put_tag(1'b0, TAG_WANTED);
					put_value(value_size());
					put_tag(1'b1, TAG_WANTED);
				end else if (pick < 63) begin
					// reopened element restarts capture
					put_tag(1'b0, TAG_WANTED);
					put_value(value_size());
					put_tag(1'b0, TAG_WANTED);
					put_value(value_size());
					put_tag(1'b1, TAG_WANTED);
				end else if (pick < 70) begin
					// document ends inside the element or inside its closing tag
					put_tag(1'b0, TAG_WANTED);
					put_value(value_size());
					if ($urandom_range(1))
						send_text(CHAR_NUL);
					else
						put_tag(1'b1, TAG_WANTED, 1'b1);
				end else if (pick < 78) begin
					put_tag(1'($urandom_range(1)), ($urandom_range(1) ? TAG_WRONG : TAG_WANTED));
					put_value($urandom_range(4));
				end else if (pick < 88) begin
					repeat ($urandom_range(6, 1))
						send_text(8'($urandom_range(255, 1)));
				end else if (pick < 94) begin
					put_tag(1'($urandom_range(1)), TAG_LONG);
				end else begin
					send_text(CHAR_NUL);
				end
			end
			steady = 1'b0;
		end

		settle();
		repeat (16) @(posedge clk);
		if (pending_values.size() != 0) begin
			$display("%0t: %0d value bytes never arrived", $time, pending_values.size());
			mismatches++;
		end
		$display("Checked %0d value bytes from %0d text bytes under %0d tag name settings", results_seen,
			texts_taken, names_set);
		$display("(empty, truncated, cut-off, reopened and oversized names included)");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
